/* rtl/plen_pkg.sv */
// Shared operation codes, status codes and field widths of the positional list engine.
package plen_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int OUTPOS_W = 7;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOCATE = 2'd2,
    KIND_GET    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_t;

endpackage

/* rtl/positional_list_engine.sv */
// Positional list engine: ordered list of signed words kept in one synchronous memory.
// One item is worked at a time; the next is taken once its result is registered.
// A rejected item goes straight to its result, and an append writes without a walk.
// The walk moves one entry per cycle.
// Reset (rst_n low at a clock edge) empties the list and drops any pending result.
module positional_list_engine #(
  parameter int CAPACITY = plen_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel. tdata fields from bit 0 up: position[7:0], value[39:8].
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [plen_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser fields from bit 0 up: kind[1:0].
  input  logic [plen_pkg::IN_TUSER_W-1:0]     in_tuser,
  // Result channel. tdata fields from bit 0 up: status[1:0], data_out[33:2],
  // found_position[40:34], list_length[47:41], is_empty[48], zero fill[55:49].
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [plen_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // Address width of the entry memory and width of the length counter.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // Comparison width: holds any position and any length plus one.
  localparam int EW = plen_pkg::POS_W + 1;
  localparam int VW = plen_pkg::VALUE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  // The entry memory. Entries at or beyond the current length are never read,
  // so the memory needs no clearing after reset.
  logic [VW-1:0] entries_r [CAPACITY];
  logic [VW-1:0] rd_data_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  state_t                    st_r,      st_nxt;
  plen_pkg::kind_t           kind_r,    kind_nxt;
  logic [plen_pkg::POS_W-1:0] pos_r,    pos_nxt;
  logic [VW-1:0]             val_r,     val_nxt;
  // Read sequencer: iss_r says another read is to be issued at cur_r, pv_r says
  // the read of the previous cycle (address pa_r) returns data this cycle.
  logic                      iss_r,     iss_nxt;
  logic [AW-1:0]             cur_r,     cur_nxt;
  logic                      pv_r,      pv_nxt;
  logic [AW-1:0]             pa_r,      pa_nxt;
  logic [CW-1:0]             cnt_r,     cnt_nxt;
  plen_pkg::status_t         status_r,  status_nxt;
  logic [VW-1:0]             data_r,    data_nxt;
  logic [CW-1:0]             found_r,   found_nxt;
  logic                      out_vld_r, out_vld_nxt;
  logic [plen_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Fields of the incoming item.
  plen_pkg::kind_t            in_kind;
  logic [plen_pkg::POS_W-1:0] in_pos;
  logic [VW-1:0]              in_val;
  logic [EW-1:0]              in_pos_e;
  logic [EW-1:0]              cnt_e;
  logic                       pos_zero;
  logic                       ins_bad;
  logic                       rng_bad;
  logic                       is_full;
  logic [plen_pkg::POS_W-1:0] in_pos_dec;
  logic [plen_pkg::POS_W-1:0] pos_dec;
  logic [CW-1:0]              cnt_dec;
  logic [AW-1:0]              pm1;
  logic [AW-1:0]              nm1;
  logic                       run_fin;
  logic                       in_xfer;
  logic                       out_free;

  assign in_kind    = plen_pkg::kind_t'(in_tuser[1:0]);
  assign in_pos     = in_tdata[plen_pkg::POS_W-1:0];
  assign in_val     = in_tdata[plen_pkg::POS_W +: VW];
  assign in_pos_e   = EW'(in_pos);
  assign cnt_e      = EW'(cnt_r);
  assign pos_zero   = (in_pos == '0);
  // Insert accepts positions 1 to length+1, delete and get 1 to length.
  assign ins_bad    = pos_zero || (in_pos_e > (cnt_e + EW'(1)));
  assign rng_bad    = pos_zero || (in_pos_e > cnt_e);
  assign is_full    = (cnt_r == CW'(CAPACITY));
  assign in_pos_dec = in_pos - 1'b1;
  assign pos_dec    = pos_r - 1'b1;
  assign cnt_dec    = cnt_r - 1'b1;
  assign pm1        = pos_dec[AW-1:0];
  assign nm1        = cnt_dec[AW-1:0];
  // The walk is over once no read is outstanding and none is left to issue.
  assign run_fin    = !iss_r && !pv_r;

  assign in_tready  = (st_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Memory port control. Insert walks downward copying each entry one place
  // back, then writes the new value into the opened slot. Delete walks upward
  // copying each entry one place forward. Reads always run ahead of the writes
  // in the walk direction, so a write never hits the entry being read.
  always_comb begin
    rd_en   = (st_r == S_RUN) && iss_r;
    rd_addr = cur_r;
    wr_en   = 1'b0;
    wr_addr = pa_r;
    wr_data = rd_data_r;
    if (st_r == S_RUN) begin
      case (kind_r)
        plen_pkg::KIND_INSERT: begin
          if (pv_r) begin
            wr_en   = 1'b1;
            wr_addr = AW'(pa_r + 1'b1);
          end else if (!iss_r) begin
            wr_en   = 1'b1;
            wr_addr = pm1;
            wr_data = val_r;
          end
        end
        plen_pkg::KIND_DELETE: begin
          if (pv_r && (pa_r != pm1)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(pa_r - 1'b1);
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entries_r[rd_addr];
    end
  end

  always_comb begin
    st_nxt       = st_r;
    kind_nxt     = kind_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    iss_nxt      = iss_r;
    cur_nxt      = cur_r;
    pv_nxt       = 1'b0;
    pa_nxt       = cur_r;
    cnt_nxt      = cnt_r;
    status_nxt   = status_r;
    data_nxt     = data_r;
    found_nxt    = found_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;

    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          kind_nxt   = in_kind;
          pos_nxt    = in_pos;
          val_nxt    = in_val;
          status_nxt = plen_pkg::STATUS_DONE;
          data_nxt   = '0;
          found_nxt  = '0;
          st_nxt     = S_RUN;
          case (in_kind)
            plen_pkg::KIND_INSERT: begin
              // Shift only when the new value lands before the tail.
              iss_nxt = (in_pos_e <= cnt_e);
              cur_nxt = nm1;
              if (ins_bad) begin
                status_nxt = plen_pkg::STATUS_RANGE;
                st_nxt     = S_DONE;
              end else if (is_full) begin
                status_nxt = plen_pkg::STATUS_FULL;
                st_nxt     = S_DONE;
              end
            end
            plen_pkg::KIND_DELETE: begin
              iss_nxt = 1'b1;
              cur_nxt = in_pos_dec[AW-1:0];
              if (rng_bad) begin
                status_nxt = plen_pkg::STATUS_RANGE;
                st_nxt     = S_DONE;
              end
            end
            plen_pkg::KIND_LOCATE: begin
              iss_nxt = (cnt_r != '0);
              cur_nxt = '0;
            end
            default: begin
              iss_nxt = 1'b1;
              cur_nxt = in_pos_dec[AW-1:0];
              if (rng_bad) begin
                status_nxt = plen_pkg::STATUS_RANGE;
                data_nxt   = '1;
                st_nxt     = S_DONE;
              end
            end
          endcase
        end
      end

      S_RUN: begin
        pv_nxt = iss_r;
        case (kind_r)
          plen_pkg::KIND_INSERT: begin
            cur_nxt = AW'(cur_r - 1'b1);
            if (iss_r && (cur_r == pm1)) begin
              iss_nxt = 1'b0;
            end
            if (run_fin) begin
              cnt_nxt = CW'(cnt_r + 1'b1);
              st_nxt  = S_DONE;
            end
          end
          plen_pkg::KIND_DELETE: begin
            cur_nxt = AW'(cur_r + 1'b1);
            if (iss_r && (cur_r == nm1)) begin
              iss_nxt = 1'b0;
            end
            if (pv_r && (pa_r == pm1)) begin
              data_nxt = rd_data_r;
            end
            if (run_fin) begin
              cnt_nxt = cnt_dec;
              st_nxt  = S_DONE;
            end
          end
          plen_pkg::KIND_LOCATE: begin
            cur_nxt = AW'(cur_r + 1'b1);
            if (iss_r && (cur_r == nm1)) begin
              iss_nxt = 1'b0;
            end
            // The first match wins; a read already in flight is ignored.
            if (pv_r && (found_r == '0) && (rd_data_r == val_r)) begin
              found_nxt = CW'(pa_r) + 1'b1;
              iss_nxt   = 1'b0;
            end
            if (run_fin) begin
              st_nxt = S_DONE;
            end
          end
          default: begin
            iss_nxt = 1'b0;
            if (pv_r) begin
              data_nxt = rd_data_r;
            end
            if (run_fin) begin
              st_nxt = S_DONE;
            end
          end
        endcase
      end

      S_DONE: begin
        iss_nxt = 1'b0;
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {7'b0, (cnt_r == '0), plen_pkg::OUTPOS_W'(cnt_r),
                          plen_pkg::OUTPOS_W'(found_r), data_r, status_r};
          st_nxt       = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      iss_r     <= 1'b0;
      pv_r      <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      iss_r     <= iss_nxt;
      pv_r      <= pv_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
    kind_r     <= kind_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    cur_r      <= cur_nxt;
    pa_r       <= pa_nxt;
    status_r   <= status_nxt;
    data_r     <= data_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  // The length never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  // A write in the walk never lands on the entry being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("memory read and write hit the same entry");

  // After an input transfer no further item is taken until the result is formed.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("second item accepted while one is in progress");

  // The length changes only when a walk finishes.
  a_cnt_changes: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_RUN) |=> $stable(cnt_r))
    else $error("list length changed outside an operation");

endmodule

/* tb/positional_list_engine_test.sv */
// Self-checking testbench for the positional list engine stream block.
module positional_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The list holds as many entries as the block's default parameter.
  localparam int LIST_CAP = plen_pkg::CAPACITY_DEF;
  // The block works one item at a time, and a locate on a full list walks every
  // entry. This many quiet cycles after the last result covers any late or
  // spurious transfer.
  localparam int SETTLE_CYCLES = LIST_CAP + 16;
  // The long receiver hold-off used to back the block up.
  localparam int HOLD_OFF_CYCLES = 300;
  // Cycles without any transfer before the run is declared hung. The slowest
  // legal gap is roughly one full-list walk plus the longest sender gap and
  // the longest receiver stall, or the hold-off above; this is several times
  // either.
  localparam int WATCHDOG_LIMIT = 2000;

  // One result as the block reports it, unpacked from out_tdata.
  typedef struct {
    plen_pkg::status_t status;
    logic [31:0]       data_out;
    logic [6:0]        found_pos;
    logic [6:0]        length;
    logic              is_empty;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // Fields from bit 0 up: position[7:0], value[39:8].
  logic [plen_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  // Fields from bit 0 up: kind[1:0].
  logic [plen_pkg::IN_TUSER_W-1:0]  in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // Fields from bit 0 up: status[1:0], data_out[33:2], found_position[40:34],
  // list_length[47:41], is_empty[48], zero fill[55:49].
  logic [plen_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the list contents, front of the queue is position 1.
  logic [31:0]  shadow_list[$];
  // Results that the block still owes, oldest first.
  list_result_t pending_results[$];

  // Random idling on both sides is switched off for some stretches.
  bit idle_enable = 1'b1;
  // A request from a test for the receiver to hold off this many cycles.
  int hold_request = 0;
  int rx_stall = 0;
  int quiet_cycles = 0;

  int mismatches = 0;
  int results_checked = 0;
  int items_sent = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  int peak_length = 0;
  int full_rejects = 0;
  int range_rejects = 0;

  positional_list_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Applies one operation to the shadow list and returns what the block
  // should report for it. Position checks come before the capacity check,
  // so a full list with position length+2 reports a range error.
  function automatic list_result_t apply_list_op(plen_pkg::kind_t kind, logic [7:0] pos,
                                                 logic [31:0] value);
    list_result_t r;
    r.status    = plen_pkg::STATUS_DONE;
    r.data_out  = '0;
    r.found_pos = '0;
    case (kind)
      plen_pkg::KIND_INSERT: begin
        if (pos == 0 || pos > shadow_list.size() + 1) begin
          r.status = plen_pkg::STATUS_RANGE;
        end else if (shadow_list.size() >= LIST_CAP) begin
          r.status = plen_pkg::STATUS_FULL;
        end else begin
          shadow_list.insert(pos - 1, value);
        end
      end
      plen_pkg::KIND_DELETE: begin
        if (pos == 0 || pos > shadow_list.size()) begin
          r.status = plen_pkg::STATUS_RANGE;
        end else begin
          r.data_out = shadow_list[pos - 1];
          shadow_list.delete(pos - 1);
        end
      end
      plen_pkg::KIND_LOCATE: begin
        // Only the first match counts; duplicates further back are ignored.
        foreach (shadow_list[i]) begin
          if (r.found_pos == 0 && shadow_list[i] == value) r.found_pos = 7'(i + 1);
        end
      end
      default: begin
        // A failed get returns all ones rather than zero.
        if (pos == 0 || pos > shadow_list.size()) begin
          r.status   = plen_pkg::STATUS_RANGE;
          r.data_out = '1;
        end else begin
          r.data_out = shadow_list[pos - 1];
        end
      end
    endcase
    r.length   = 7'(shadow_list.size());
    r.is_empty = (shadow_list.size() == 0);
    return r;
  endfunction

  // Gap length in cycles: mostly none, sometimes short, rarely long.
  function automatic int next_gap();
    int roll;
    roll = $urandom_range(99);
    if (!idle_enable || roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Values lean on a small pool, so that locate sees duplicates, and on the
  // extremes of the signed range.
  function automatic logic [31:0] random_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return $urandom;
    if (roll < 75) return $urandom_range(7) - 4;
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Offers one item on the input channel and waits for its transfer. Inputs
  // change only at falling edges; the expected result is recorded at the
  // rising edge of the transfer. tvalid is left high so that back-to-back
  // items need no extra assignment.
  task automatic send_item(plen_pkg::kind_t kind, logic [7:0] pos, logic [31:0] value);
    int gap;
    list_result_t expected;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {value, pos};
    do @(posedge clk); while (!in_tready);
    expected = apply_list_op(kind, pos, value);
    pending_results.push_back(expected);
    items_sent++;
    kind_count[kind]++;
    if (expected.length > peak_length) peak_length = expected.length;
    if (expected.status == plen_pkg::STATUS_FULL) full_rejects++;
    if (expected.status == plen_pkg::STATUS_RANGE) range_rejects++;
  endtask

  // One random operation. Most positions are legal for the current length;
  // the rest are zero or past the end, up to the top of the position field.
  task automatic send_random_op(int insert_pct, int delete_pct, int locate_pct);
    int roll;
    int len;
    int valid_hi;
    plen_pkg::kind_t kind;
    logic [7:0] pos;
    logic [31:0] value;
    roll = $urandom_range(99);
    if (roll < insert_pct) kind = plen_pkg::KIND_INSERT;
    else if (roll < insert_pct + delete_pct) kind = plen_pkg::KIND_DELETE;
    else if (roll < insert_pct + delete_pct + locate_pct) kind = plen_pkg::KIND_LOCATE;
    else kind = plen_pkg::KIND_GET;
    len = shadow_list.size();
    valid_hi = (kind == plen_pkg::KIND_INSERT) ? len + 1 : len;
    roll = $urandom_range(99);
    if (roll < 5) pos = 8'd0;
    else if (roll < 15 || valid_hi == 0) pos = 8'($urandom_range(255, valid_hi + 1));
    else pos = 8'($urandom_range(valid_hi, 1));
    value = random_value();
    // Locate mostly searches for something that is there.
    if (kind == plen_pkg::KIND_LOCATE && len > 0 && $urandom_range(99) < 60)
      value = shadow_list[$urandom_range(len - 1)];
    send_item(kind, pos, value);
  endtask

  // Extremes of every field and each error case, starting from an empty list.
  task automatic test_directed_cases();
    send_item(plen_pkg::KIND_LOCATE, 8'd0,   32'h0000_0000);  // locate on an empty list
    send_item(plen_pkg::KIND_GET,    8'd1,   32'h0000_0000);  // get on an empty list
    send_item(plen_pkg::KIND_DELETE, 8'd1,   32'h0000_0000);  // delete on an empty list
    send_item(plen_pkg::KIND_INSERT, 8'd0,   32'h1234_5678);  // position zero
    send_item(plen_pkg::KIND_INSERT, 8'd2,   32'h1234_5678);  // one past length+1
    send_item(plen_pkg::KIND_INSERT, 8'd1,   32'h8000_0000);  // first entry, most negative
    send_item(plen_pkg::KIND_INSERT, 8'd2,   32'h7fff_ffff);  // append at the tail
    send_item(plen_pkg::KIND_INSERT, 8'd1,   32'hffff_ffff);  // insert at the head
    send_item(plen_pkg::KIND_INSERT, 8'd2,   32'h0000_0000);  // insert in the middle
    send_item(plen_pkg::KIND_INSERT, 8'd255, 32'h0000_0001);  // top of the position field
    send_item(plen_pkg::KIND_LOCATE, 8'd255, 32'h7fff_ffff);  // match in the last slot
    send_item(plen_pkg::KIND_LOCATE, 8'd0,   32'h0000_0001);  // no match
    send_item(plen_pkg::KIND_LOCATE, 8'd7,   32'hffff_ffff);  // match in the first slot
    send_item(plen_pkg::KIND_GET,    8'd0,   32'hdead_beef);
    send_item(plen_pkg::KIND_GET,    8'd4,   32'h0000_0000);
    send_item(plen_pkg::KIND_GET,    8'd5,   32'h0000_0000);
    send_item(plen_pkg::KIND_GET,    8'd255, 32'h0000_0000);
    send_item(plen_pkg::KIND_DELETE, 8'd0,   32'h0000_0000);
    send_item(plen_pkg::KIND_DELETE, 8'd5,   32'h0000_0000);
    send_item(plen_pkg::KIND_DELETE, 8'd2,   32'hffff_ffff);  // middle, closes the gap
    send_item(plen_pkg::KIND_DELETE, 8'd3,   32'h0000_0000);  // tail
    send_item(plen_pkg::KIND_DELETE, 8'd1,   32'h0000_0000);  // head
    send_item(plen_pkg::KIND_DELETE, 8'd1,   32'h0000_0000);  // last entry, list empties
    send_item(plen_pkg::KIND_INSERT, 8'd1,   32'h0000_0005);
    send_item(plen_pkg::KIND_LOCATE, 8'd0,   32'h0000_0005);
  endtask

  // Fills the list to capacity at random positions, probes the full-list
  // cases, then empties it again at random positions.
  task automatic test_fill_to_capacity();
    while (shadow_list.size() < LIST_CAP)
      send_item(plen_pkg::KIND_INSERT, 8'($urandom_range(shadow_list.size() + 1, 1)),
                random_value());
    send_item(plen_pkg::KIND_INSERT, 8'd1, random_value());             // full
    send_item(plen_pkg::KIND_INSERT, 8'(LIST_CAP + 1), random_value()); // full, at the tail
    send_item(plen_pkg::KIND_INSERT, 8'(LIST_CAP + 2), random_value()); // range beats full
    send_item(plen_pkg::KIND_INSERT, 8'd0, random_value());
    send_item(plen_pkg::KIND_LOCATE, 8'd0, shadow_list[LIST_CAP - 1]);
    send_item(plen_pkg::KIND_LOCATE, 8'd0, random_value());
    send_item(plen_pkg::KIND_GET, 8'(LIST_CAP), 32'h0000_0000);
    send_item(plen_pkg::KIND_GET, 8'(LIST_CAP + 1), 32'h0000_0000);
    send_item(plen_pkg::KIND_DELETE, 8'(LIST_CAP + 1), 32'h0000_0000);
    while (shadow_list.size() > 0) begin
      if ($urandom_range(3) == 0)
        send_item(plen_pkg::KIND_GET, 8'($urandom_range(shadow_list.size(), 1)), $urandom);
      send_item(plen_pkg::KIND_DELETE, 8'($urandom_range(shadow_list.size(), 1)), $urandom);
    end
  endtask

  // The bulk of the run: alternating stretches that grow and shrink the list,
  // so lengths sweep from empty to full and back. Every fourth stretch runs
  // with no idling on either side.
  task automatic test_random_mix(int n_items);
    bit grow;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        grow = ((i / 150) % 2 == 0);
        idle_enable = ((i / 150) % 4 != 3);
      end
      if (grow) send_random_op(60, 10, 15);
      else send_random_op(15, 40, 23);
    end
    idle_enable = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items back to back, so results back up and the input stalls.
  task automatic test_output_stall();
    idle_enable  = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (30) send_random_op(40, 20, 20);
    idle_enable = 1'b1;
  endtask

  // Result channel ready. A pending hold-off request overrides any random
  // stall; otherwise ready drops now and then for a random number of cycles.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      rx_stall = hold_request;
      hold_request = 0;
    end else if (rx_stall == 0 && idle_enable && $urandom_range(99) < 20) begin
      rx_stall = next_gap();
    end
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic compare_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    list_result_t expected;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        expected = pending_results.pop_front();
        compare_field("status",         32'(expected.status),    32'(out_tdata[1:0]));
        compare_field("data_out",       expected.data_out,       out_tdata[33:2]);
        compare_field("found_position", 32'(expected.found_pos), 32'(out_tdata[40:34]));
        compare_field("list_length",    32'(expected.length),    32'(out_tdata[47:41]));
        compare_field("is_empty",       32'(expected.is_empty),  32'(out_tdata[48]));
        results_checked++;
      end
    end
  end

  // Ends a hung run: any cycle with a transfer on either side restarts the count.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : run_tests
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_fill_to_capacity();
    test_random_mix(1200);
    test_output_stall();

    // Stop offering, collect the remaining results, then stay a while to
    // catch anything the block sends that nobody asked for.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d transfers: %0d inserts, %0d deletes, %0d locates, %0d gets.",
             results_checked, items_sent, kind_count[plen_pkg::KIND_INSERT],
             kind_count[plen_pkg::KIND_DELETE], kind_count[plen_pkg::KIND_LOCATE],
             kind_count[plen_pkg::KIND_GET]);
    $display("List length peaked at %0d; %0d inserts refused as full, %0d bad positions.",
             peak_length, full_rejects, range_rejects);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
